// File: design/adp_pkg.sv
`timescale 1ns / 1ps

package adp_pkg;

    localparam int SIG_LEN   = 12;
    localparam int NUM_LEN   = 4;
    localparam int BYTE_W    = 8;
    localparam int POS_W     = 4;
    localparam int WORD_W    = 32;
    localparam int INDEX_W   = 16;
    localparam int NAME_LO_W = 64;
    localparam int NAME_HI_W = 32;
    localparam int LEN_W     = 4;
    localparam int ADDR_W    = 3;
    localparam int APB_W     = 32;

    localparam logic [INDEX_W-1:0] MAX_ENTRIES_RST = 16'd4096;
    localparam logic [BYTE_W-1:0]  CHAR_SPACE      = 8'h20;
    localparam logic [WORD_W-1:0]  HEADER_BYTES    = 32'd16;

    localparam logic [0:0] REG_MAX_ENTRIES = 1'b0;

    typedef enum logic [2:0] {
        PH_SIG   = 3'd0,
        PH_COUNT = 3'd1,
        PH_NAME  = 3'd2,
        PH_SIZE  = 3'd3,
        PH_IDLE  = 3'd4
    } t_phase;

    typedef enum logic [2:0] {
        ST_OK          = 3'd0,
        ST_SHORT_SIG   = 3'd1,
        ST_BAD_SIG     = 3'd2,
        ST_SHORT_COUNT = 3'd3,
        ST_TOO_MANY    = 3'd4,
        ST_SHORT_NAME  = 3'd5,
        ST_SHORT_SIZE  = 3'd6
    } t_status;

    typedef struct packed {
        t_status                status;
        logic                   has_entry;
        logic [INDEX_W-1:0]     entry_index;
        logic [NAME_LO_W-1:0]   name_low;
        logic [NAME_HI_W-1:0]   name_high;
        logic [LEN_W-1:0]       name_length;
        logic [WORD_W-1:0]      entry_size;
        logic [WORD_W-1:0]      entry_offset;
        logic                   index_complete;
        logic [INDEX_W-1:0]     total_entries;
    } t_result;

    function automatic logic [BYTE_W-1:0] sig_byte(input logic [POS_W-1:0] pos);
        logic [BYTE_W-1:0] b;
        begin
            unique case (pos)
                4'd0:    b = 8'h4B;
                4'd1:    b = 8'h65;
                4'd2:    b = 8'h6E;
                4'd3:    b = 8'h53;
                4'd4:    b = 8'h69;
                4'd5:    b = 8'h6C;
                4'd6:    b = 8'h76;
                4'd7:    b = 8'h65;
                4'd8:    b = 8'h72;
                4'd9:    b = 8'h6D;
                4'd10:   b = 8'h61;
                4'd11:   b = 8'h6E;
                default: b = 8'h00;
            endcase
            return b;
        end
    endfunction

endpackage

// File: design/adp_if.sv
`timescale 1ns / 1ps

interface adp_in_if
    import adp_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] data_byte;
    logic              is_end;

    modport source (output valid, output data_byte, output is_end, input ready);
    modport sink   (input valid, input data_byte, input is_end, output ready);
endinterface

interface adp_out_if
    import adp_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [2:0]           status;
    logic                 has_entry;
    logic [INDEX_W-1:0]   entry_index;
    logic [NAME_LO_W-1:0] name_low;
    logic [NAME_HI_W-1:0] name_high;
    logic [LEN_W-1:0]     name_length;
    logic [WORD_W-1:0]    entry_size;
    logic [WORD_W-1:0]    entry_offset;
    logic                 index_complete;
    logic [INDEX_W-1:0]   total_entries;

    modport source (
        output valid, output status, output has_entry, output entry_index,
        output name_low, output name_high, output name_length, output entry_size,
        output entry_offset, output index_complete, output total_entries,
        input ready
    );
    modport sink (
        input valid, input status, input has_entry, input entry_index,
        input name_low, input name_high, input name_length, input entry_size,
        input entry_offset, input index_complete, input total_entries,
        output ready
    );
endinterface

// File: design/archive_directory_parser.sv
`timescale 1ns / 1ps

// archive directory parser
// i_in carries one archive word per handshake: a data byte and an end flag.
// the block checks the 12-byte signature, reads the 32-bit little-endian entry
// count, then parses 16-byte entries (12-byte name, 32-bit size).
// o_out carries at most one result word per input word: an error status, one
// parsed entry with its trimmed name, size and data offset, or completion.
// an end flag rearms the parser; it reports a short read when it comes early.
// the apb port holds max_entries at address 0, sampled on the last count byte.
// a result passes from the input register to the result register. throughput:
// one word per cycle while the receiver takes results, set by the single-pass
// step logic between the two registers. when the receiver stalls, the result
// register holds, the input register keeps its word and i_in.ready falls once
// the input register is full.
// reset (synchronous, active low) empties both registers, restores
// max_entries to 4096 and returns the parser to the signature phase.
module archive_directory_parser
    import adp_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    adp_in_if.sink            i_in,
    adp_out_if.source         o_out,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [APB_W-1:0]  pwdata,
    output logic [APB_W-1:0]  prdata,
    output logic              pready
);

    logic [INDEX_W-1:0] r_max_entries;

    logic              r_in_valid;
    logic [BYTE_W-1:0] r_in_byte;
    logic              r_in_end;

    t_phase             r_phase, n_phase;
    logic [POS_W-1:0]   r_byte_pos, n_byte_pos;
    logic               r_sig_mis, n_sig_mis;
    logic [WORD_W-1:0]  r_count, n_count;
    logic [INDEX_W-1:0] r_entries, n_entries;
    logic [LEN_W-1:0]   r_last_kept, n_last_kept;
    logic [WORD_W-1:0]  r_size, n_size;
    logic [WORD_W-1:0]  r_offset, n_offset;
    logic [BYTE_W-1:0]  r_name [SIG_LEN];

    logic    r_out_valid, n_out_valid;
    t_result r_out, n_out;

    logic               w_advance;
    logic               w_step;
    logic               w_sig_bad;
    logic               w_last_sig;
    logic               w_last_num;
    logic [4:0]         w_shift;
    logic [WORD_W-1:0]  w_count_full;
    logic [WORD_W-1:0]  w_size_full;
    logic               w_too_many;
    logic [INDEX_W-1:0] w_entries_inc;
    logic               w_last_entry;
    logic               w_kept_byte;
    logic [NAME_LO_W-1:0] w_name_lo;
    logic [NAME_HI_W-1:0] w_name_hi;

    // config port
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_MAX_ENTRIES) ? APB_W'(r_max_entries) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_entries <= MAX_ENTRIES_RST;
        end else if (psel && penable && pwrite && pready && paddr[2] == REG_MAX_ENTRIES) begin
            r_max_entries <= pwdata[INDEX_W-1:0];
        end
    end

    // handshake
    assign w_advance  = !r_out_valid || o_out.ready;
    assign w_step     = r_in_valid && w_advance;
    assign i_in.ready = !r_in_valid || w_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.valid && i_in.ready) begin
            r_in_valid <= 1'b1;
        end else if (w_step) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in_byte <= i_in.data_byte;
            r_in_end  <= i_in.is_end;
        end
    end

    // shared step conditions
    assign w_last_sig    = (r_byte_pos == POS_W'(SIG_LEN - 1));
    assign w_last_num    = (r_byte_pos == POS_W'(NUM_LEN - 1));
    assign w_sig_bad     = r_sig_mis || (r_in_byte != sig_byte(r_byte_pos));
    assign w_shift       = {r_byte_pos[1:0], 3'b000};
    assign w_count_full  = r_count | (WORD_W'(r_in_byte) << w_shift);
    assign w_size_full   = r_size | (WORD_W'(r_in_byte) << w_shift);
    assign w_too_many    = w_count_full > WORD_W'(r_max_entries);
    assign w_entries_inc = r_entries + 1'b1;
    assign w_last_entry  = (w_entries_inc == r_count[INDEX_W-1:0]);
    assign w_kept_byte   = (r_in_byte != CHAR_SPACE) && (r_in_byte != '0);

    // trimmed name
    always_comb begin
        w_name_lo = '0;
        w_name_hi = '0;
        for (int i = 0; i < 8; i++) begin
            if (LEN_W'(i) < r_last_kept) begin
                w_name_lo[8*i +: 8] = r_name[i];
            end
        end
        for (int i = 0; i < SIG_LEN - 8; i++) begin
            if (LEN_W'(i + 8) < r_last_kept) begin
                w_name_hi[8*i +: 8] = r_name[i + 8];
            end
        end
    end

    // next phase
    always_comb begin
        n_phase = r_phase;
        if (w_step) begin
            if (r_in_end) begin
                n_phase = PH_SIG;
            end else begin
                unique case (r_phase)
                    PH_SIG: begin
                        if (w_last_sig) begin
                            n_phase = w_sig_bad ? PH_IDLE : PH_COUNT;
                        end
                    end
                    PH_COUNT: begin
                        if (w_last_num) begin
                            n_phase = (w_too_many || w_count_full == '0) ? PH_IDLE : PH_NAME;
                        end
                    end
                    PH_NAME: begin
                        if (w_last_sig) begin
                            n_phase = PH_SIZE;
                        end
                    end
                    PH_SIZE: begin
                        if (w_last_num) begin
                            n_phase = w_last_entry ? PH_IDLE : PH_NAME;
                        end
                    end
                    default: n_phase = PH_IDLE;
                endcase
            end
        end
    end

    // datapath and result
    always_comb begin
        n_byte_pos  = r_byte_pos;
        n_sig_mis   = r_sig_mis;
        n_count     = r_count;
        n_entries   = r_entries;
        n_last_kept = r_last_kept;
        n_size      = r_size;
        n_offset    = r_offset;
        n_out_valid = 1'b0;
        n_out       = '0;
        if (w_step) begin
            if (r_in_end) begin
                n_byte_pos  = '0;
                n_sig_mis   = 1'b0;
                n_count     = '0;
                n_entries   = '0;
                n_last_kept = '0;
                n_size      = '0;
                n_offset    = '0;
                n_out_valid = (r_phase != PH_IDLE);
                unique case (r_phase)
                    PH_SIG:   n_out.status = ST_SHORT_SIG;
                    PH_COUNT: n_out.status = ST_SHORT_COUNT;
                    PH_NAME:  n_out.status = ST_SHORT_NAME;
                    PH_SIZE:  n_out.status = ST_SHORT_SIZE;
                    default:  n_out.status = ST_OK;
                endcase
            end else begin
                unique case (r_phase)
                    PH_SIG: begin
                        n_sig_mis  = w_sig_bad;
                        n_byte_pos = r_byte_pos + 1'b1;
                        if (w_last_sig) begin
                            n_byte_pos = '0;
                            if (w_sig_bad) begin
                                n_out_valid  = 1'b1;
                                n_out.status = ST_BAD_SIG;
                            end
                        end
                    end
                    PH_COUNT: begin
                        n_count    = w_count_full;
                        n_byte_pos = r_byte_pos + 1'b1;
                        if (w_last_num) begin
                            n_byte_pos = '0;
                            if (w_too_many) begin
                                n_out_valid  = 1'b1;
                                n_out.status = ST_TOO_MANY;
                            end else begin
                                n_offset    = HEADER_BYTES + {w_count_full[WORD_W-5:0], 4'b0000};
                                n_entries   = '0;
                                n_last_kept = '0;
                                if (w_count_full == '0) begin
                                    n_out_valid          = 1'b1;
                                    n_out.index_complete = 1'b1;
                                end
                            end
                        end
                    end
                    PH_NAME: begin
                        n_byte_pos = r_byte_pos + 1'b1;
                        if (w_kept_byte) begin
                            n_last_kept = r_byte_pos + 1'b1;
                        end
                        if (w_last_sig) begin
                            n_byte_pos = '0;
                            n_size     = '0;
                        end
                    end
                    PH_SIZE: begin
                        n_size     = w_size_full;
                        n_byte_pos = r_byte_pos + 1'b1;
                        if (w_last_num) begin
                            n_byte_pos         = '0;
                            n_out_valid        = 1'b1;
                            n_out.has_entry    = 1'b1;
                            n_out.entry_index  = r_entries;
                            n_out.name_low     = w_name_lo;
                            n_out.name_high    = w_name_hi;
                            n_out.name_length  = r_last_kept;
                            n_out.entry_size   = w_size_full;
                            n_out.entry_offset = r_offset;
                            n_offset           = r_offset + w_size_full;
                            n_entries          = w_entries_inc;
                            n_last_kept        = '0;
                            if (w_last_entry) begin
                                n_out.index_complete = 1'b1;
                                n_out.total_entries  = r_count[INDEX_W-1:0];
                            end
                        end
                    end
                    default: begin
                        n_byte_pos = r_byte_pos;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_SIG;
            r_byte_pos  <= '0;
            r_sig_mis   <= 1'b0;
            r_count     <= '0;
            r_entries   <= '0;
            r_last_kept <= '0;
            r_size      <= '0;
            r_offset    <= '0;
        end else begin
            r_phase     <= n_phase;
            r_byte_pos  <= n_byte_pos;
            r_sig_mis   <= n_sig_mis;
            r_count     <= n_count;
            r_entries   <= n_entries;
            r_last_kept <= n_last_kept;
            r_size      <= n_size;
            r_offset    <= n_offset;
        end
    end

    // name bytes
    always_ff @(posedge i_clk) begin
        if (w_step && !r_in_end && r_phase == PH_NAME) begin
            r_name[r_byte_pos] <= r_in_byte;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_out <= n_out;
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.status         = r_out.status;
    assign o_out.has_entry      = r_out.has_entry;
    assign o_out.entry_index    = r_out.entry_index;
    assign o_out.name_low       = r_out.name_low;
    assign o_out.name_high      = r_out.name_high;
    assign o_out.name_length    = r_out.name_length;
    assign o_out.entry_size     = r_out.entry_size;
    assign o_out.entry_offset   = r_out.entry_offset;
    assign o_out.index_complete = r_out.index_complete;
    assign o_out.total_entries  = r_out.total_entries;

    a_out_from_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(w_step))
        else $error("result appeared without a step");

    a_in_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !w_step |=> r_in_valid)
        else $error("pending input word lost");

    a_entry_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && (r_out.has_entry || r_out.index_complete) |-> r_out.status == ST_OK)
        else $error("entry or completion with error status");

    a_total_only_complete: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_out.index_complete |-> r_out.total_entries == '0)
        else $error("total entries without completion");

    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_COUNT || r_phase == PH_SIZE) |-> r_byte_pos < POS_W'(NUM_LEN))
        else $error("byte position out of range in numeric field");

endmodule
